// ----- rtl/core/bpss_pkg.sv -----
package bpss_pkg;

  localparam logic [7:0] CharM     = 8'h4D;
  localparam logic [7:0] CharCaret = 8'h5E;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char1     = 8'h31;
  localparam logic [7:0] Char9     = 8'h39;

  localparam logic [7:0] UniqueLen = 8'd23;
  localparam logic [7:0] LegLen    = 8'd37;
  localparam logic [7:0] OffsetMax = 8'hFF;
  localparam logic [7:0] MaxLegs   = 8'd9;

  localparam logic CfgSkipVar  = 1'b0;
  localparam logic CfgCheckEnd = 1'b1;

  typedef enum logic [3:0] {
    PhIdle,
    PhUm,
    PhLm,
    PhSkip,
    PhUc,
    PhRc,
    PhInd,
    PhTail,
    PhSec,
    PhPost,
    PhErr
  } bpss_phase_e;

  typedef enum logic [2:0] {
    TagUniqueMand = 3'd0,
    TagLegMand    = 3'd1,
    TagUniqueCond = 3'd2,
    TagLegCond    = 3'd3,
    TagIndividual = 3'd4,
    TagSecurity   = 3'd5,
    TagSkipped    = 3'd6,
    TagDiscarded  = 3'd7
  } bpss_tag_e;

  typedef enum logic [3:0] {
    ErrNone      = 4'd0,
    ErrFormat    = 4'd1,
    ErrLegCount  = 4'd2,
    ErrLegCaret  = 4'd3,
    ErrHexSize   = 4'd4,
    ErrNoGt      = 4'd5,
    ErrOverrun   = 4'd6,
    ErrTruncated = 4'd7,
    ErrTrailing  = 4'd8
  } bpss_err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
  } bpss_in_t;

  typedef struct packed {
    logic [2:0] section_tag;
    logic [3:0] leg_number;
    logic [7:0] offset_in_section;
    logic [3:0] error_code;
    logic       frame_done;
    logic       frame_ok;
  } bpss_out_t;

  typedef struct packed {
    bpss_phase_e phase;
    logic [7:0]  offset;
    logic [3:0]  leg_total;
    logic [3:0]  leg_cur;
    logic [7:0]  var_rem;
    logic [7:0]  sub_rem;
    logic [3:0]  hex_hi;
  } bpss_state_t;

  localparam bpss_state_t StateReset = '{
    phase:     PhIdle,
    offset:    8'd0,
    leg_total: 4'd0,
    leg_cur:   4'd0,
    var_rem:   8'd0,
    sub_rem:   8'd0,
    hex_hi:    4'd0
  };

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd16;
    if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
    else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h37;
    else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h57;
    return d[4:0];
  endfunction

endpackage

// ----- rtl/core/bpss_step.sv -----
module bpss_step (
  input  bpss_pkg::bpss_state_t state_i,
  input  bpss_pkg::bpss_in_t    beat_i,
  input  logic                  skip_var_i,
  input  logic                  check_end_i,
  output bpss_pkg::bpss_state_t state_o,
  output bpss_pkg::bpss_out_t   result_o
);
  import bpss_pkg::*;

  bpss_state_t s;
  bpss_tag_e   tag;
  bpss_err_e   err;
  logic [3:0]  leg;
  logic [7:0]  off;
  logic [7:0]  b;
  logic [7:0]  digit;
  logic [7:0]  size;
  logic [4:0]  h;
  logic        done;
  logic        ok;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == OffsetMax) ? v : v + 8'd1;
  endfunction

  function automatic bpss_state_t leg_done(input bpss_state_t st);
    bpss_state_t r;
    r = st;
    r.offset = 8'd0;
    if (st.leg_cur < st.leg_total) begin
      r.leg_cur = st.leg_cur + 4'd1;
      r.phase   = PhLm;
    end else begin
      r.phase = PhTail;
    end
    return r;
  endfunction

  assign b     = beat_i.data_byte;
  assign h     = hex_digit(b);
  assign digit = b - Char0;

  always_comb begin
    s    = state_i;
    tag  = TagDiscarded;
    err  = ErrNone;
    leg  = 4'd0;
    off  = 8'd0;
    size = 8'd0;
    done = 1'b0;
    ok   = 1'b0;

    if (beat_i.frame_start) begin
      s       = StateReset;
      s.phase = PhUm;
    end

    if (s.phase != PhIdle && s.phase != PhErr) begin
      if (s.phase == PhTail && !skip_var_i && b == CharCaret) begin
        s.phase  = PhSec;
        s.offset = 8'd0;
      end
      off = s.offset;

      case (s.phase)
        PhUm: begin
          tag = TagUniqueMand;
          if (off == 8'd0 && b != CharM) begin
            err = ErrFormat;
          end else if (off == 8'd1) begin
            if (!(b inside {[Char1:Char9]}) || digit > MaxLegs) err = ErrLegCount;
            else s.leg_total = digit[3:0];
          end
          if (err == ErrNone) begin
            if (off >= UniqueLen - 8'd1) begin
              s.phase   = PhLm;
              s.leg_cur = 4'd1;
              s.offset  = 8'd0;
            end else begin
              s.offset = sat_inc(s.offset);
            end
          end
        end

        PhLm: begin
          tag = TagLegMand;
          leg = s.leg_cur;
          if (off == 8'd0 && b == CharCaret) begin
            err = ErrLegCaret;
          end else if (off inside {LegLen - 8'd2, LegLen - 8'd1}) begin
            if (h[4]) err = ErrHexSize;
            else if (off == LegLen - 8'd2) s.hex_hi = h[3:0];
          end
          if (err == ErrNone) begin
            if (off >= LegLen - 8'd1) begin
              size      = {s.hex_hi, h[3:0]};
              s.var_rem = size;
              s.offset  = 8'd0;
              if (size == 8'd0) s = leg_done(s);
              else if (skip_var_i) s.phase = PhSkip;
              else s.phase = (s.leg_cur == 4'd1) ? PhUc : PhRc;
            end else begin
              s.offset = sat_inc(s.offset);
            end
          end
        end

        PhSkip, PhInd: begin
          tag = (s.phase == PhSkip) ? TagSkipped : TagIndividual;
          leg = s.leg_cur;
          if (s.var_rem != 8'd0) s.var_rem = s.var_rem - 8'd1;
          s.offset = sat_inc(s.offset);
          if (s.var_rem == 8'd0) s = leg_done(s);
        end

        PhUc: begin
          tag = TagUniqueCond;
          leg = s.leg_cur;
          if (off == 8'd0) begin
            if (s.var_rem < 8'd4) err = ErrOverrun;
            else if (b != CharGt) err = ErrNoGt;
          end else if (off inside {8'd2, 8'd3}) begin
            if (h[4]) begin
              err = ErrHexSize;
            end else if (off == 8'd2) begin
              s.hex_hi = h[3:0];
            end else begin
              size = {s.hex_hi, h[3:0]};
              if ({1'b0, size} + 9'd2 > {1'b0, s.var_rem - 8'd1}) err = ErrOverrun;
              else s.sub_rem = size;
            end
          end
          if (err == ErrNone) begin
            s.var_rem = s.var_rem - 8'd1;
            if (off < 8'd3) begin
              s.offset = sat_inc(s.offset);
            end else begin
              if (off > 8'd3 && s.sub_rem != 8'd0) s.sub_rem = s.sub_rem - 8'd1;
              s.offset = sat_inc(s.offset);
              if (s.sub_rem == 8'd0) begin
                s.phase  = PhRc;
                s.offset = 8'd0;
              end
            end
          end
        end

        PhRc: begin
          tag = TagLegCond;
          leg = s.leg_cur;
          if (off == 8'd0 && s.var_rem < 8'd2) begin
            err = ErrOverrun;
          end else if (off < 8'd2) begin
            if (h[4]) begin
              err = ErrHexSize;
            end else if (off == 8'd0) begin
              s.hex_hi = h[3:0];
            end else begin
              size = {s.hex_hi, h[3:0]};
              if (size > s.var_rem - 8'd1) err = ErrOverrun;
              else s.sub_rem = size;
            end
          end
          if (err == ErrNone) begin
            if (s.var_rem != 8'd0) s.var_rem = s.var_rem - 8'd1;
            if (off == 8'd0) begin
              s.offset = sat_inc(s.offset);
            end else begin
              if (off > 8'd1 && s.sub_rem != 8'd0) s.sub_rem = s.sub_rem - 8'd1;
              s.offset = sat_inc(s.offset);
              if (s.sub_rem == 8'd0) begin
                s.offset = 8'd0;
                if (s.var_rem == 8'd0) s = leg_done(s);
                else s.phase = PhInd;
              end
            end
          end
        end

        PhSec: begin
          tag = TagSecurity;
          if (off inside {8'd2, 8'd3}) begin
            if (h[4]) err = ErrHexSize;
            else if (off == 8'd2) s.hex_hi = h[3:0];
            else s.sub_rem = {s.hex_hi, h[3:0]};
          end
          if (err == ErrNone) begin
            if (off < 8'd3) begin
              s.offset = sat_inc(s.offset);
            end else begin
              if (off > 8'd3 && s.sub_rem != 8'd0) s.sub_rem = s.sub_rem - 8'd1;
              s.offset = sat_inc(s.offset);
              if (s.sub_rem == 8'd0) begin
                s.phase  = PhPost;
                s.offset = 8'd0;
              end
            end
          end
        end

        default: begin
          off = 8'd0;
          if (skip_var_i) begin
            tag = TagSkipped;
          end else begin
            tag = TagDiscarded;
            if (check_end_i) err = ErrTrailing;
            else s.phase = PhPost;
          end
        end
      endcase

      if (err != ErrNone) begin
        done = 1'b1;
      end else if (beat_i.frame_end) begin
        done = 1'b1;
        if (s.phase == PhTail || s.phase == PhPost) begin
          ok      = 1'b1;
          s.phase = PhIdle;
        end else begin
          err = ErrTruncated;
        end
      end
      if (err != ErrNone) s.phase = PhErr;
    end
  end

  assign state_o                    = s;
  assign result_o.section_tag       = tag;
  assign result_o.leg_number        = leg;
  assign result_o.offset_in_section = off;
  assign result_o.error_code        = err;
  assign result_o.frame_done        = done;
  assign result_o.frame_ok          = ok;

endmodule

// ----- rtl/core/boarding_pass_section_splitter.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o   bpss_in_t  (byte, frame start, frame end)
// out       output     out_valid_o/out_ready_i bpss_out_t (tag, leg, offset, error, done, ok)
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One byte per cycle sustained while the output is not stalled; each beat is held in the input
// register and then in the result register, from which it leaves.
// The parse state advances when a beat moves from the input to the result register.
// A stalled result holds; the input register still takes a beat and waits behind it.
// Reset clears the parse state to idle, the variable-part skip to 0 and check_end to 1.
module boarding_pass_section_splitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpss_pkg::bpss_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpss_pkg::bpss_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic                cfg_data_i
);
  import bpss_pkg::*;

  bpss_in_t    in_q;
  logic        in_valid_q;
  bpss_out_t   out_q;
  logic        out_valid_q;
  bpss_state_t state_q;
  bpss_state_t state_d;
  bpss_out_t   result;
  logic        skip_var_q;
  logic        check_end_q;
  logic        advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  bpss_step u_step (
    .state_i    (state_q),
    .beat_i     (in_q),
    .skip_var_i (skip_var_q),
    .check_end_i(check_end_q),
    .state_o    (state_d),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_var_q  <= 1'b0;
      check_end_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgSkipVar) skip_var_q <= cfg_data_i;
      if (cfg_idx_i == CfgCheckEnd) check_end_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_valid_i && in_ready_o) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_ok_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_ok |-> out_q.frame_done && out_q.error_code == ErrNone)
    else $error("frame_ok without clean frame_done");

  a_err_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result.error_code != ErrNone |=> state_q.phase == PhErr)
    else $error("error beat did not stop the parse");

  a_leg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.leg_cur <= state_q.leg_total)
    else $error("current leg above leg count");
`endif

endmodule
